[sv/multi_waveform_generator_assert.svh]
// assertion macros for the waveform generator
`ifndef MULTI_WAVEFORM_GENERATOR_ASSERT_SVH
`define MULTI_WAVEFORM_GENERATOR_ASSERT_SVH

// cond in one cycle implies expr in the next
`define MWG_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("waveform generator check failed");

// cond implies expr in the same cycle
`define MWG_ASSERT_NOW(lbl, clk, rst_n, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("waveform generator check failed");

`endif

[sv/mwg_pkg.sv]
// shared types, constants and sine table builder for the waveform generator
package mwg_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_DEPTH     = 1 << SINE_ADDR_BITS;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] LFSR_SEED   = 16'hACE1;

  localparam logic [2:0]  MODE_RESET  = 3'd0;
  localparam logic [31:0] FREQ_RESET  = 32'd89478485;
  localparam logic [15:0] AMP_RESET   = 16'd32768;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_SINE   = 3'd1,
    MODE_COSINE = 3'd2,
    MODE_SAW    = 3'd3,
    MODE_TRI    = 3'd4,
    MODE_SQUARE = 3'd5,
    MODE_NOISE  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_FREQ = 2'd1,
    REG_AMP  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROM,
    ST_GAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_phase;
    logic do_rom;
    logic do_gain;
    logic do_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // quarter-wave entry: taylor series to x^11 in Q30, truncating
  function automatic logic [14:0] rom_entry(input int unsigned a);
    logic [63:0] t32;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    begin
      t32  = (64'(a) * 64'd2 + 64'd1) << (31 - SINE_ADDR_BITS);
      x    = (t32 * HALF_PI_Q30) >> 32;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return v[14:0];
    end
  endfunction

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t rom;
    begin
      for (int i = 0; i < SINE_DEPTH; i++) begin
        rom[i] = rom_entry(i);
      end
      return rom;
    end
  endfunction

endpackage

[sv/multi_waveform_generator.sv]
// the controller walks the phase multiply, sine table read, gain multiply and
// output load in turn; the input stays stalled until the output load, so a new
// item is only taken once the last one has been loaded into the output register
// a stalled result holds the next item in its final step until taken
// reset (synchronous, rst_n low) restores registers and seeds the noise lfsr
// top level of the multi-mode waveform generator
`include "multi_waveform_generator_assert.svh"

module multi_waveform_generator import mwg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_sample_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mwg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mwg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample_index  (in_sample_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value)
  );

  // an accepted item keeps the input stalled while it is worked on
  `MWG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // a stalled result stays valid and keeps its value
  `MWG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sample_value))
  // the input is only open while no item is in flight
  `MWG_ASSERT_NOW(a_idle_no_cmd, clk, rst_n, !in_stall, !(cmd.do_phase || cmd.do_out))

endmodule

[sv/mwg_ctrl.sv]
// sequencing state machine for the waveform generator
module mwg_ctrl import mwg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd.do_phase = 1'b1;
        state_nxt    = ST_ROM;
      end
      ST_ROM: begin
        cmd.do_rom = 1'b1;
        state_nxt  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.do_gain = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!sts.out_busy) begin
          cmd.do_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/mwg_datapath.sv]
// phase multiply, waveform shaping, gain and output register
module mwg_datapath import mwg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        in_sample_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_value
);

  localparam sine_rom_t SINE_ROM = sine_rom_init();

  mode_t       mode_r;
  logic [31:0] freq_r;
  logic [15:0] amp_r;
  logic [15:0] lfsr_r, lfsr_nxt;

  logic [31:0]               n_r;
  logic [31:0]               phase_r;
  logic [14:0]               rom_q_r;
  logic                      neg_r;
  logic                      sine_sel_r;
  logic signed [15:0]        wave_r, wave_nxt;
  logic signed [32:0]        prod_r;
  logic                      out_valid_r;
  logic signed [15:0]        out_value_r;

  logic [31:0]               phase_full;
  logic [PHASE_BITS-1:0]     p;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic signed [15:0]        s;
  logic [16:0]               s_abs;
  logic signed [17:0]        tri_v;
  logic signed [16:0]        noise_v;
  logic signed [15:0]        v;
  logic signed [17:0]        y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mode_t'(MODE_RESET);
      freq_r <= FREQ_RESET;
      amp_r  <= AMP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode_r <= mode_t'(cfg_data[2:0]);
        REG_FREQ: freq_r <= cfg_data;
        REG_AMP:  amp_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // only the low word of the product is the phase
  assign phase_full = n_r * freq_r;
  assign p          = phase_r[31 -: PHASE_BITS];
  assign s          = $signed(p[PHASE_BITS-1 -: 16]);
  assign s_abs      = s[15] ? 17'(-$signed({s[15], s})) : {1'b0, s};
  assign tri_v      = $signed({s_abs, 1'b0}) - 18'sd32768;

  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
  assign noise_v  = $signed({1'b0, lfsr_nxt[14:0], 1'b0}) - 17'sd32768;

  always_comb begin
    quad = p[PHASE_BITS-1 -: 2];
    if (mode_r == MODE_COSINE) begin
      quad = quad + 2'd1;
    end
    addr = p[PHASE_BITS-3 -: SINE_ADDR_BITS];
    // odd quadrants run the table backwards
    if (quad[0]) begin
      addr = ~addr;
    end
  end

  always_comb begin
    case (mode_r)
      MODE_SAW:    wave_nxt = s;
      MODE_TRI:    wave_nxt = (tri_v > 18'sd32767) ? 16'sh7FFF : tri_v[15:0];
      MODE_SQUARE: wave_nxt = p[PHASE_BITS-1] ? 16'sh8000 : 16'sh7FFF;
      MODE_NOISE:  wave_nxt = noise_v[15:0];
      default:     wave_nxt = '0;
    endcase
  end

  always_comb begin
    v = wave_r;
    if (sine_sel_r) begin
      v = neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
    end
  end

  assign y = prod_r[32:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (cmd.do_rom && mode_r == MODE_NOISE) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      n_r <= in_sample_index;
    end
    if (cmd.do_phase) begin
      phase_r <= phase_full;
    end
    if (cmd.do_rom) begin
      rom_q_r    <= SINE_ROM[addr];
      neg_r      <= quad[1];
      sine_sel_r <= (mode_r == MODE_SINE) || (mode_r == MODE_COSINE);
      wave_r     <= wave_nxt;
    end
    if (cmd.do_gain) begin
      prod_r <= v * $signed({1'b0, amp_r});
    end
    if (cmd.do_out) begin
      if (y > 18'sd32767) begin
        out_value_r <= 16'sh7FFF;
      end else if (y < -18'sd32768) begin
        out_value_r <= 16'sh8000;
      end else begin
        out_value_r <= y[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy     = out_valid_r & out_stall;
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule

[tb/sv/multi_waveform_generator_tb.sv]
// self-checking testbench for the multi-mode waveform generator
`timescale 1ns / 100ps

module multi_waveform_generator_tb import mwg_pkg::*; ();

  localparam int          QUIET_LIMIT   = 2000;
  localparam logic [31:0] FREQ_AT_RESET = 32'd89478485;
  localparam logic [15:0] AMP_AT_RESET  = 16'd32768;
  localparam logic [15:0] NOISE_SEED    = 16'hACE1;
  localparam logic [15:0] NOISE_TAPS    = 16'hB400;
  localparam logic [63:0] HALF_PI_FRAC  = 64'd1686629713;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam logic [2:0]  MODE_UNUSED   = 3'd7;

  class waveform_scoreboard;
    logic [2:0]         wave_mode;
    logic [31:0]        freq_word;
    logic [15:0]        amplitude;
    logic [15:0]        noise_lfsr;
    int                 quarter_sine [SINE_DEPTH];
    logic signed [15:0] expected_samples [$];
    int unsigned        mismatches;

    function new();
      wave_mode  = MODE_NONE;
      freq_word  = FREQ_AT_RESET;
      amplitude  = AMP_AT_RESET;
      noise_lfsr = NOISE_SEED;
      mismatches = 0;
      for (int a = 0; a < SINE_DEPTH; a++) begin
        quarter_sine[a] = taylor_sine(a);
      end
    endfunction

    // Q30 taylor series up to x^11 at the middle of table slot a
    function int taylor_sine(int unsigned a);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned scaled;
      ang  = 64'(2 * a + 1) << (31 - SINE_ADDR_BITS);
      ang  = (ang * HALF_PI_FRAC) >> 32;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int k = 1; k <= 5; k++) begin
        term = ((term * ang2) >> 30) / 64'(2 * k * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      scaled = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (scaled > 64'd32767) begin
        scaled = 64'd32767;
      end
      return int'(scaled);
    endfunction

    function int sine_at(logic [31:0] p);
      logic [SINE_ADDR_BITS-1:0] addr;
      int                        level;
      addr = p[29 -: SINE_ADDR_BITS];
      // odd quadrants read the table backwards
      if (p[30]) begin
        addr = ~addr;
      end
      level = quarter_sine[addr];
      return p[31] ? -level : level;
    endfunction

    function logic signed [15:0] predict_sample(logic [31:0] n);
      logic [31:0] phase;
      int          level;
      int          saw;
      logic        shifted_out;
      longint      scaled;
      phase = n * freq_word;
      case (wave_mode)
        MODE_SINE: begin
          level = sine_at(phase);
        end
        MODE_COSINE: begin
          level = sine_at(phase + 32'h4000_0000);
        end
        MODE_SAW: begin
          level = $signed(phase[31:16]);
        end
        MODE_TRI: begin
          saw   = $signed(phase[31:16]);
          level = 2 * (saw < 0 ? -saw : saw) - 32768;
          if (level > 32767) begin
            level = 32767;
          end
        end
        MODE_SQUARE: begin
          level = phase[31] ? -32768 : 32767;
        end
        MODE_NOISE: begin
          shifted_out = noise_lfsr[0];
          noise_lfsr  = noise_lfsr >> 1;
          if (shifted_out) begin
            noise_lfsr = noise_lfsr ^ NOISE_TAPS;
          end
          level = 2 * int'(noise_lfsr[14:0]) - 32768;
        end
        default: begin
          level = 0;
        end
      endcase
      scaled = longint'(level) * longint'(amplitude);
      scaled = scaled >>> 15;
      if (scaled > 32767) begin
        scaled = 32767;
      end else if (scaled < -32768) begin
        scaled = -32768;
      end
      return scaled[15:0];
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MODE: wave_mode = data[2:0];
        REG_FREQ: freq_word = data;
        REG_AMP:  amplitude = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [31:0] n);
      expected_samples.push_back(predict_sample(n));
    endfunction

    function void check_sample(logic signed [15:0] actual);
      logic signed [15:0] wanted;
      if (expected_samples.size() == 0) begin
        $error("sample_value arrived with no item pending: actual %0d", actual);
        mismatches++;
      end else begin
        wanted = expected_samples.pop_front();
        if (actual !== wanted) begin
          $error("sample_value mismatch: expected %0d, actual %0d", wanted, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void report_leftover();
      if (expected_samples.size() != 0) begin
        $error("sample_value: %0d expected items never arrived", expected_samples.size());
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_sample_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  waveform_scoreboard sb = new();
  int                 quiet_cycles = 0;
  logic [5:0]         stall_tick = '0;
  logic [1:0]         stall_style = '0;

  multi_waveform_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_index  (in_sample_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver picks a new stall style each time the 6-bit stall_tick wraps to zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) begin
      stall_style <= 2'($urandom_range(0, 3));
    end
    case (stall_style)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_tick[4];
    endcase
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_sample(out_sample_value);
      end
      if (in_valid && !in_stall) begin
        sb.note_request(in_sample_index);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic write_one(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] mode_data, input logic [31:0] freq_data,
                            input logic [31:0] amp_data, input bit touch_spare);
    if (touch_spare) begin
      write_one(REG_SPARE, $urandom);
    end
    write_one(REG_FREQ, freq_data);
    write_one(REG_AMP, amp_data);
    write_one(REG_MODE, mode_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] n);
    in_valid        <= 1'b1;
    in_sample_index <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // mostly consecutive sample numbers, sent in bursts
  task automatic send_stream(input int count);
    int          left;
    int          burst;
    int          gap;
    logic [31:0] n;
    n    = $urandom;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 9) < 7) begin
          n = n + 32'd1;
        end else begin
          n = $urandom;
        end
        send_sample(n);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic run_random_phase(input int ph);
    logic [31:0] mode_data;
    logic [31:0] freq_data;
    logic [31:0] amp_data;
    mode_data = $urandom;
    if (ph < 8) begin
      mode_data[2:0] = 3'(ph);
    end else begin
      mode_data[2:0] = 3'($urandom_range(1, 6));
    end
    case ($urandom_range(0, 4))
      0: freq_data = 32'h0000_0000;
      1: freq_data = 32'hFFFF_FFFF;
      2: freq_data = $urandom_range(1, 65536);
      default: freq_data = $urandom;
    endcase
    amp_data = $urandom;
    case ($urandom_range(0, 4))
      0: amp_data[15:0] = 16'd0;
      1: amp_data[15:0] = 16'd32768;
      2: amp_data[15:0] = 16'hFFFF;
      3: amp_data[15:0] = 16'($urandom_range(0, 32768));
      default: ;
    endcase
    set_config(mode_data, freq_data, amp_data, $urandom_range(0, 3) == 0);
    send_stream(42);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: mode none
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    drain();

    // quarter-turn steps hit each quadrant of sine and cosine
    set_config(MODE_SINE, 32'h4000_0000, 32'd32768, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(i);
    drain();
    set_config(MODE_COSINE, 32'h4000_0000, 32'd32768, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(i);
    drain();

    // unit step: phase equals the sample number, so ramp extremes are direct
    set_config(MODE_SAW, 32'd1, 32'd32768, 1'b0);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    drain();
    set_config(MODE_TRI, 32'd1, 32'd32768, 1'b0);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    drain();

    // gain above unity saturates both levels
    set_config(MODE_SQUARE, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    drain();

    set_config(MODE_NOISE, $urandom, 32'd20000, 1'b0);
    for (int i = 0; i < 3; i++) send_sample($urandom);
    drain();

    // unused mode code gives zero; spare register index is ignored
    set_config({29'h1FFF_FFFF, MODE_UNUSED}, 32'h1234_5678, 32'hABCD_8000, 1'b1);
    send_sample($urandom);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      run_random_phase(ph);
    end

    repeat (10) @(posedge clk);
    sb.report_leftover();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
